[design/swt_pkg.sv]
// Shared types and constants for the software timer wheel.
`default_nettype none
package swt_pkg;

    localparam int SLOTS   = 16;
    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ID_W    = 4;
    localparam int PER_W   = 16;
    localparam int DLY_W   = 24;
    localparam int EL_W    = 17;
    localparam int ACC_W   = 18;
    localparam int TICK_W  = 32;
    localparam int CNT_W   = $clog2(DLY_W);

    localparam logic [PER_W-1:0] PERIOD_RST = PER_W'(10);

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_DEL    = 2'd1;
    localparam logic [1:0] FUNC_REPORT = 2'd2;

    localparam logic [1:0] KIND_ACCEPT  = 2'd0;
    localparam logic [1:0] KIND_REFUSED = 2'd1;
    localparam logic [1:0] KIND_EXPIRED = 2'd2;
    localparam logic [1:0] KIND_REPORT  = 2'd3;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DECODE = 8'b0000_0010,
        ST_DIV    = 8'b0000_0100,
        ST_ARM    = 8'b0000_1000,
        ST_CHECK  = 8'b0001_0000,
        ST_MARK   = 8'b0010_0000,
        ST_SEL    = 8'b0100_0000,
        ST_PICK   = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic       load;
        logic       div_step;
        logic       arm;
        logic       del;
        logic       acc_add;
        logic       acc_sub;
        logic       idx_clr;
        logic       mark;
        logic       tick_inc;
        logic       sel;
        logic       expire;
        logic       emit;
        logic [1:0] emit_kind;
        logic       emit_last;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       id_ok;
        logic       running_id;
        logic       div_done;
        logic       acc_ge;
        logic       idx_last;
        logic       found;
    } stat_t;

endpackage
`default_nettype wire

[design/swt_ctrl.sv]
// Controller state machine for the software timer wheel.
`default_nettype none
module swt_ctrl
    import swt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire stat_t stat,
    output cmd_t       cmd,
    output logic       busy
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.func == FUNC_ADD && stat.id_ok)
                begin
                    if (stat.running_id)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = KIND_REFUSED;
                        cmd.emit_last = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
                else if (stat.func == FUNC_REPORT)
                begin
                    cmd.acc_add = 1'b1;
                    state_next  = ST_CHECK;
                end
                else
                begin
                    cmd.del       = (stat.func == FUNC_DEL) && stat.id_ok;
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_ACCEPT;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = ST_ARM;
                end
            end
            ST_ARM:
            begin
                cmd.arm       = 1'b1;
                cmd.emit      = 1'b1;
                cmd.emit_kind = KIND_ACCEPT;
                cmd.emit_last = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_CHECK:
            begin
                cmd.idx_clr = 1'b1;
                if (stat.acc_ge)
                begin
                    cmd.acc_sub = 1'b1;
                    state_next  = ST_MARK;
                end
                else
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_REPORT;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_MARK:
            begin
                cmd.mark = 1'b1;
                if (stat.idx_last)
                begin
                    cmd.tick_inc = 1'b1;
                    state_next   = ST_SEL;
                end
            end
            ST_SEL:
            begin
                cmd.sel = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                cmd.idx_clr = 1'b1;
                if (stat.found)
                begin
                    cmd.expire    = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_EXPIRED;
                    state_next    = ST_SEL;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[design/swt_dp.sv]
// Datapath: slot store, tick and millisecond counters, divider and oldest-first selection.
`default_nettype none
module swt_dp
    import swt_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [PER_W-1:0]         cfg_wdata,
    input  wire logic [1:0]               func,
    input  wire logic [ID_W-1:0]          timer_id,
    input  wire logic [DLY_W-1:0]         delay_ms,
    input  wire logic signed [EL_W-1:0]   elapsed_ms,
    input  wire cmd_t                     cmd,
    output stat_t                         stat,
    output logic                          result_valid,
    output logic [1:0]                    kind,
    output logic [ID_W-1:0]               expired_id,
    output logic [TICK_W-1:0]             tick_now,
    output logic                          last
);

    logic [PER_W-1:0]  period_reg;
    logic [TICK_W-1:0] tick_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [TICK_W-1:0] seq_reg;
    logic [SLOTS-1:0]  running_reg;
    logic [SLOTS-1:0]  due_reg;
    logic [TICK_W-1:0] exp_reg [SLOTS];
    logic [TICK_W-1:0] ord_reg [SLOTS];
    logic [1:0]        func_reg;
    logic [ID_W-1:0]   id_reg;
    logic [EL_W-1:0]   el_reg;
    logic [DLY_W-1:0]  quo_reg;
    logic [PER_W:0]    rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [TICK_W-1:0] best_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  pick_reg;
    logic              valid_reg;
    logic [1:0]        kind_reg;
    logic [ID_W-1:0]   eid_reg;
    logic [TICK_W-1:0] tnow_reg;
    logic              last_reg;

    logic [IDX_W-1:0]  slot;
    logic [PER_W-1:0]  cfg_period;
    logic [PER_W:0]    rem_shift;
    logic              rem_ge;
    logic [PER_W:0]    rem_next;
    logic [ACC_W-1:0]  tri_period;
    logic [PER_W-1:0]  el_pos;
    logic [PER_W-1:0]  el_use;
    logic [ACC_W-1:0]  acc_sum;
    logic [TICK_W-1:0] age;
    logic              better;

    assign slot       = id_reg[IDX_W-1:0];
    assign cfg_period = (cfg_wdata == '0) ? PER_W'(1) : cfg_wdata;
    assign rem_shift  = {rem_reg[PER_W-1:0], quo_reg[DLY_W-1]};
    assign rem_ge     = rem_shift >= {1'b0, period_reg};
    assign rem_next   = rem_ge ? (rem_shift - {1'b0, period_reg}) : rem_shift;
    assign tri_period = ACC_W'({period_reg, 1'b0}) + ACC_W'(period_reg);
    assign el_pos     = el_reg[EL_W-1] ? '0 : el_reg[PER_W-1:0];
    assign el_use     = (ACC_W'(el_pos) >= tri_period) ? period_reg : el_pos;
    assign acc_sum    = acc_reg + ACC_W'(el_use);
    assign age        = seq_reg - ord_reg[idx_reg];
    assign better     = due_reg[idx_reg] && (!found_reg || age > best_reg);

    assign stat.func       = func_reg;
    assign stat.id_ok      = ((ID_W+1)'(id_reg) < (ID_W+1)'(SLOTS));
    assign stat.running_id = running_reg[slot];
    assign stat.div_done   = (cnt_reg == CNT_W'(DLY_W-1));
    assign stat.acc_ge     = (acc_reg >= ACC_W'(period_reg));
    assign stat.idx_last   = (idx_reg == IDX_W'(SLOTS-1));
    assign stat.found      = found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= PERIOD_RST;
            tick_reg    <= '0;
            acc_reg     <= ACC_W'(PERIOD_RST);
            seq_reg     <= '0;
            running_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit;
            if (cfg_we)
            begin
                period_reg <= cfg_period;
                tick_reg   <= '0;
                acc_reg    <= ACC_W'(cfg_period);
            end
            else
            begin
                if (cmd.acc_add)
                begin
                    acc_reg <= acc_sum;
                end
                else if (cmd.acc_sub)
                begin
                    acc_reg <= acc_reg - ACC_W'(period_reg);
                end
                if (cmd.tick_inc)
                begin
                    tick_reg <= tick_reg + TICK_W'(1);
                end
            end
            if (cmd.arm)
            begin
                running_reg[slot] <= 1'b1;
                seq_reg           <= seq_reg + TICK_W'(1);
            end
            if (cmd.del)
            begin
                running_reg[slot] <= 1'b0;
            end
            if (cmd.expire)
            begin
                running_reg[pick_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            id_reg   <= timer_id;
            el_reg   <= elapsed_ms;
            quo_reg  <= delay_ms;
            rem_reg  <= '0;
            cnt_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[DLY_W-2:0], rem_ge};
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (cmd.arm)
        begin
            exp_reg[slot] <= tick_reg + TICK_W'(quo_reg);
            ord_reg[slot] <= seq_reg;
        end
        if (cmd.idx_clr)
        begin
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        if (cmd.mark)
        begin
            due_reg[idx_reg] <= running_reg[idx_reg] && (exp_reg[idx_reg] == tick_reg);
            idx_reg          <= idx_reg + IDX_W'(1);
        end
        if (cmd.sel)
        begin
            if (better)
            begin
                found_reg <= 1'b1;
                best_reg  <= age;
                pick_reg  <= idx_reg;
            end
            idx_reg <= idx_reg + IDX_W'(1);
        end
        if (cmd.expire)
        begin
            due_reg[pick_reg] <= 1'b0;
        end
        if (cmd.emit)
        begin
            kind_reg <= cmd.emit_kind;
            tnow_reg <= tick_reg;
            last_reg <= cmd.emit_last;
            case (cmd.emit_kind)
                KIND_EXPIRED: eid_reg <= ID_W'(pick_reg);
                KIND_REPORT:  eid_reg <= '0;
                default:      eid_reg <= id_reg;
            endcase
        end
    end

    assign result_valid = valid_reg;
    assign kind         = kind_reg;
    assign expired_id   = eid_reg;
    assign tick_now     = tnow_reg;
    assign last         = last_reg;

endmodule
`default_nettype wire

[design/software_timer_wheel.sv]
// Top level of the software timer wheel: controller plus datapath.
//
//  channel   | handshake                    | payload
//  request   | start, busy                  | func, timer_id, delay_ms, elapsed_ms
//  result    | result_valid (one cycle)     | kind, expired_id, tick_now, last
//  config    | cfg_we                       | cfg_wdata (tick period, ms)
//
// Add: decode, 24-step restoring divide, arm, output register; delete: decode, output
// register. Report: decode, then per tick a check, mark scan, and oldest-first select
// scan and pick per expiry plus one more; each slot scan visits one slot a cycle.
// Reset leaves tick 0, period 10, accumulator 10 and all slots stopped.
// The receiver cannot stall; a request is taken only while busy is low.
`default_nettype none
module software_timer_wheel
    import swt_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [PER_W-1:0]         cfg_wdata,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [1:0]               func,
    input  wire logic [ID_W-1:0]          timer_id,
    input  wire logic [DLY_W-1:0]         delay_ms,
    input  wire logic signed [EL_W-1:0]   elapsed_ms,
    output logic                          result_valid,
    output logic [1:0]                    kind,
    output logic [ID_W-1:0]               expired_id,
    output logic [TICK_W-1:0]             tick_now,
    output logic                          last
);

    cmd_t  cmd;
    stat_t stat;

    swt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    swt_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .func         (func),
        .timer_id     (timer_id),
        .delay_ms     (delay_ms),
        .elapsed_ms   (elapsed_ms),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .kind         (kind),
        .expired_id   (expired_id),
        .tick_now     (tick_now),
        .last         (last)
    );

endmodule
`default_nettype wire

[design/swt_chk.sv]
// Port-level checker for the software timer wheel, bound to the top level.
`default_nettype none
module swt_chk
    import swt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire logic              result_valid,
    input  wire logic [1:0]        kind,
    input  wire logic [ID_W-1:0]   expired_id,
    input  wire logic              last
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request taken without going busy");

    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> busy)
        else $error("non-final result while idle");

    a_expiry_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KIND_EXPIRED |-> !last)
        else $error("expiry marked final");

    a_report_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KIND_REPORT |-> last && expired_id == '0)
        else $error("report result malformed");

endmodule

bind software_timer_wheel swt_chk u_swt_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .kind         (kind),
    .expired_id   (expired_id),
    .last         (last)
);
`default_nettype wire
